// ===== src/cscan_pkg.sv =====
package cscan_pkg;

  // Sizes of the request table and of the word fields.
  localparam int unsigned QUEUE_DEPTH = 16;
  localparam int unsigned TRACK_WIDTH = 16;
  localparam int unsigned ID_WIDTH    = 4;
  localparam int unsigned IDX_WIDTH   = $clog2(QUEUE_DEPTH);

  // Index of the last table entry, where a scan ends.
  localparam logic [IDX_WIDTH-1:0] SCAN_LAST = IDX_WIDTH'(QUEUE_DEPTH - 1);

  // Action code of an input word.
  typedef enum logic {
    ACT_REQUEST = 1'b0,
    ACT_RELEASE = 1'b1
  } action_e;

  typedef logic [TRACK_WIDTH-1:0] track_t;
  typedef logic [ID_WIDTH-1:0]    id_t;
  typedef logic [IDX_WIDTH-1:0]   idx_t;

  // Input word.
  typedef struct packed {
    action_e action;
    track_t  track;
    id_t     requester;
  } in_word_t;

  // Result word.
  typedef struct packed {
    logic   grant_valid;
    id_t    grant_requester;
    track_t grant_track;
    logic   dropped;
    logic   busy_res;
  } out_word_t;

  // Commands from the sequencer to the scan unit.
  typedef struct packed {
    logic clear;
    logic step;
    idx_t idx;
  } scan_ctl_t;

  // Winner reported by the scan unit.
  typedef struct packed {
    logic   found;
    idx_t   idx;
    track_t track;
    id_t    requester;
  } pick_t;

endpackage

// ===== src/cscan_disk_request_scheduler_unit.sv =====
// Channel | Direction | Handshake            | Word
// --------+-----------+----------------------+------------------------------
// in      | input     | in_valid_i/in_stall_o | in_word_i (action, track, id)
// out     | output    | out_valid_o/out_stall_i | out_word_o (grant, drop, busy)
//
// A request word's result is loaded into the output register when the word is accepted.
// A release word scans the table: the scan unit visits one table entry per cycle,
// then the finish state applies the grant once the output register is free.
// Reset empties the table at once (valid bits) and leaves the disk idle.
// A stalled result holds the output register and stalls the input side.
module cscan_disk_request_scheduler_unit (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  cscan_pkg::in_word_t  in_word_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output cscan_pkg::out_word_t out_word_o
);
  import cscan_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_FINISH = 3'b100
  } state_e;

  state_e    state_q, state_d;
  idx_t      idx_q, idx_d;
  logic      busy_q, busy_d;
  track_t    head_q, head_d;
  logic      out_valid_q, out_valid_d;
  out_word_t out_word_q, out_word_d;

  logic      out_free;
  logic      in_accept;
  logic      load;
  logic      tbl_wr;
  logic      tbl_clr;
  logic      tbl_full;
  logic      ent_valid;
  track_t    ent_track;
  id_t       ent_req;
  scan_ctl_t scan_ctl;
  pick_t     pick;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = !((state_q == ST_IDLE) && out_free);
  assign in_accept  = in_valid_i && !in_stall_o;

  cscan_table u_table (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .wr_en_i        (tbl_wr),
    .wr_track_i     (in_word_i.track),
    .wr_requester_i (in_word_i.requester),
    .clr_en_i       (tbl_clr),
    .clr_idx_i      (pick.idx),
    .rd_idx_i       (idx_q),
    .full_o         (tbl_full),
    .rd_valid_o     (ent_valid),
    .rd_track_o     (ent_track),
    .rd_requester_o (ent_req)
  );

  cscan_scan_unit u_scan (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctl_i           (scan_ctl),
    .floor_i         (head_q),
    .ent_valid_i     (ent_valid),
    .ent_track_i     (ent_track),
    .ent_requester_i (ent_req),
    .pick_o          (pick)
  );

  // Sequencer: requests finish on acceptance, releases scan the table.
  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    busy_d     = busy_q;
    head_d     = head_q;
    load       = 1'b0;
    out_word_d = out_word_q;
    tbl_wr     = 1'b0;
    tbl_clr    = 1'b0;
    scan_ctl   = '{clear: 1'b0, step: 1'b0, idx: idx_q};

    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          out_word_d = '0;
          if (in_word_i.action == ACT_REQUEST) begin
            load = 1'b1;
            if (!busy_q) begin
              busy_d                     = 1'b1;
              head_d                     = in_word_i.track;
              out_word_d.grant_valid     = 1'b1;
              out_word_d.grant_requester = in_word_i.requester;
              out_word_d.grant_track     = in_word_i.track;
            end else if (tbl_full) begin
              out_word_d.dropped = 1'b1;
            end else begin
              tbl_wr = 1'b1;
            end
            out_word_d.busy_res = 1'b1;
          end else begin
            scan_ctl.clear = 1'b1;
            idx_d          = '0;
            state_d        = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        scan_ctl.step = 1'b1;
        if (idx_q == SCAN_LAST) begin
          state_d = ST_FINISH;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          load       = 1'b1;
          out_word_d = '0;
          if (pick.found) begin
            tbl_clr                    = 1'b1;
            busy_d                     = 1'b1;
            head_d                     = pick.track;
            out_word_d.grant_valid     = 1'b1;
            out_word_d.grant_requester = pick.requester;
            out_word_d.grant_track     = pick.track;
          end else begin
            busy_d = 1'b0;
          end
          out_word_d.busy_res = busy_d;
          state_d             = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Output register: filled on load, emptied when taken.
  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      busy_q      <= 1'b0;
      head_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      busy_q      <= busy_d;
      head_q      <= head_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_word_q <= out_word_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

// ===== src/cscan_table.sv =====
module cscan_table (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              wr_en_i,
  input  cscan_pkg::track_t wr_track_i,
  input  cscan_pkg::id_t    wr_requester_i,
  input  logic              clr_en_i,
  input  cscan_pkg::idx_t   clr_idx_i,
  input  cscan_pkg::idx_t   rd_idx_i,
  output logic              full_o,
  output logic              rd_valid_o,
  output cscan_pkg::track_t rd_track_o,
  output cscan_pkg::id_t    rd_requester_o
);
  import cscan_pkg::*;

  logic [QUEUE_DEPTH-1:0] valid_q, valid_d;
  track_t                 track_q [QUEUE_DEPTH];
  id_t                    req_q   [QUEUE_DEPTH];
  idx_t                   free_idx;
  logic                   free_found;

  // Lowest-indexed free entry.
  always_comb begin
    free_idx   = '0;
    free_found = 1'b0;
    for (int i = QUEUE_DEPTH - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_idx   = IDX_WIDTH'(i);
        free_found = 1'b1;
      end
    end
  end

  assign full_o = !free_found;

  // Valid bits: set on a store, cleared when an entry is granted.
  always_comb begin
    valid_d = valid_q;
    if (wr_en_i && free_found) begin
      valid_d[free_idx] = 1'b1;
    end
    if (clr_en_i) begin
      valid_d[clr_idx_i] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Entry payload needs no reset; it is read only while valid.
  always_ff @(posedge clk_i) begin
    if (wr_en_i && free_found) begin
      track_q[free_idx] <= wr_track_i;
      req_q[free_idx]   <= wr_requester_i;
    end
  end

  assign rd_valid_o     = valid_q[rd_idx_i];
  assign rd_track_o     = track_q[rd_idx_i];
  assign rd_requester_o = req_q[rd_idx_i];

endmodule

// ===== src/cscan_scan_unit.sv =====
module cscan_scan_unit (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cscan_pkg::scan_ctl_t ctl_i,
  input  cscan_pkg::track_t    floor_i,
  input  logic                 ent_valid_i,
  input  cscan_pkg::track_t    ent_track_i,
  input  cscan_pkg::id_t       ent_requester_i,
  output cscan_pkg::pick_t     pick_o
);
  import cscan_pkg::*;

  // Best entry at or above the head, and best entry overall.
  pick_t hi_q, hi_d;
  pick_t any_q, any_d;
  logic  at_floor;
  logic  beats_hi;
  logic  beats_any;

  // One entry per step; strict less-than keeps the lowest index on ties.
  assign at_floor  = ent_track_i >= floor_i;
  assign beats_hi  = !hi_q.found || (ent_track_i < hi_q.track);
  assign beats_any = !any_q.found || (ent_track_i < any_q.track);

  always_comb begin
    hi_d  = hi_q;
    any_d = any_q;
    if (ctl_i.clear) begin
      hi_d.found  = 1'b0;
      any_d.found = 1'b0;
    end else if (ctl_i.step && ent_valid_i) begin
      if (at_floor && beats_hi) begin
        hi_d = '{found: 1'b1, idx: ctl_i.idx, track: ent_track_i,
                 requester: ent_requester_i};
      end
      if (beats_any) begin
        any_d = '{found: 1'b1, idx: ctl_i.idx, track: ent_track_i,
                  requester: ent_requester_i};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hi_q  <= '0;
      any_q <= '0;
    end else begin
      hi_q  <= hi_d;
      any_q <= any_d;
    end
  end

  // With nothing at or above the head the scan wraps to the smallest track.
  assign pick_o = hi_q.found ? hi_q : any_q;

endmodule

// ===== src/cscan_checker.sv =====
module cscan_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_stall_o,
  input cscan_pkg::in_word_t  in_word_i,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input cscan_pkg::out_word_t out_word_o
);
  import cscan_pkg::*;

  // A word never both grants and reports a drop.
  a_grant_or_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_word_o.grant_valid && out_word_o.dropped))
    else $error("grant and drop in the same word");

  // A grant or a drop leaves the disk busy.
  a_busy_after: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_word_o.grant_valid || out_word_o.dropped))
      |-> out_word_o.busy_res)
    else $error("grant or drop without busy disk");

  // Without a grant the grant fields read zero.
  a_zero_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_word_o.grant_valid)
      |-> (out_word_o.grant_track == '0) && (out_word_o.grant_requester == '0))
    else $error("grant fields set without grant");

  // An accepted request produces its result word on the next cycle.
  a_request_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && (in_word_i.action == ACT_REQUEST))
      |=> out_valid_o)
    else $error("request word without result");

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_word_o)))
    else $error("stalled result word changed");

endmodule

bind cscan_disk_request_scheduler_unit cscan_checker u_cscan_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_word_i   (in_word_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_word_o  (out_word_o)
);
